// File: src/kmf_pkg.sv
// kmf_pkg: shared types and constants of the keyed message fifo
// command and result codes, controller/datapath command and status structs
// no dependencies
package kmf_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 16;

  // operation codes carried in the cmd field
  typedef enum logic [2:0] {
    CMD_ENQ      = 3'd0,
    CMD_PEEK     = 3'd1,
    CMD_DEQ      = 3'd2,
    CMD_FIND_SO  = 3'd3,
    CMD_FIND_SER = 3'd4,
    CMD_REM_SO   = 3'd5,
    CMD_REM_SER  = 3'd6,
    CMD_REM_SS   = 3'd7
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } stat_e;

  // read address source for the slot memories
  typedef enum logic [1:0] {
    RD_TAIL = 2'd0,
    RD_HEAD = 2'd1,
    RD_LINK = 2'd2
  } rd_sel_e;

  // how the unlink operands are captured
  typedef enum logic [1:0] {
    UL_NONE      = 2'd0,
    UL_FROM_RD   = 2'd1,
    UL_TAIL_PRED = 2'd2
  } ul_sel_e;

  // commands from controller to datapath
  typedef struct packed {
    logic    capture;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    walk_start;
    logic    walk_inc;
    logic    scan_clr;
    logic    scan_inc;
    logic    enq_write;
    logic    link_wr_pl;
    ul_sel_e ul_sel;
    logic    unlink;
    logic    res_we;
    stat_e   res_status;
    logic    res_hit;
    logic    out_load;
  } kmf_ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic empty;
    logic single;
    logic full;
    logic match;
    logic rd_is_tail;
    logic link_is_tail;
    logic scan_free;
    logic walk_last;
  } kmf_stat_t;

endpackage

// File: src/kmf_if.sv
// kmf_req_if, kmf_rsp_if: valid/ready channels of the keyed message fifo
// depends on kmf_pkg for the default depth
interface kmf_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [7:0]  dest_module;
  logic [7:0]  source_module;
  logic [31:0] serial_number;
  logic [7:0]  option_code;
  logic [15:0] message_kind;
  logic [15:0] body_length;

  modport source (output valid, cmd, dest_module, source_module, serial_number,
                  option_code, message_kind, body_length, input ready);
  modport sink (input valid, cmd, dest_module, source_module, serial_number,
                option_code, message_kind, body_length, output ready);
endinterface

interface kmf_rsp_if import kmf_pkg::*; #(
  parameter int unsigned CNT_W = $clog2(DEF_QUEUE_DEPTH + 1)
);
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [7:0]       hit_dest;
  logic [7:0]       hit_source;
  logic [31:0]      hit_serial;
  logic [7:0]       hit_option;
  logic [15:0]      hit_kind;
  logic [15:0]      hit_length;
  logic [CNT_W-1:0] entries_left;

  modport source (output valid, status, hit_dest, hit_source, hit_serial, hit_option,
                  hit_kind, hit_length, entries_left, input ready);
  modport sink (input valid, status, hit_dest, hit_source, hit_serial, hit_option,
                hit_kind, hit_length, entries_left, output ready);
endinterface

// File: src/keyed_message_fifo.sv
// keyed_message_fifo: fifo of message headers with keyed find and removal
// top level; depends on kmf_pkg, kmf_if, kmf_ctrl, kmf_datapath
//
//   channel  dir  beat contents
//   req_i    in   cmd, dest_module, source_module, serial_number, option_code,
//                 message_kind, body_length
//   rsp_o    out  status, hit_dest/source/serial/option/kind/length, entries_left
//
// one item at a time; the slot memories have one registered read port, so a ring
// walk reads the queued entries one after another
// enqueue: scan for the lowest free slot, write it, and link the old tail to it when
// the queue was not empty; peek/dequeue: read the head; find/remove: walk the ring
// (tail is checked first; when the tail is removed, a second walk from the head finds its predecessor)
// reset clears valid bits, head, tail and count; no clearing pass
// a waiting result sits in the output register; a new beat is taken meanwhile
module keyed_message_fifo import kmf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  kmf_req_if.sink   req_i,
  kmf_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  kmf_ctrl_t ctrl;
  kmf_stat_t stat;

  // sequencing
  kmf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .in_cmd_i    (cmd_e'(req_i.cmd)),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // storage and result path
  kmf_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .cmd_i           (cmd_e'(req_i.cmd)),
    .dest_module_i   (req_i.dest_module),
    .source_module_i (req_i.source_module),
    .serial_number_i (req_i.serial_number),
    .option_code_i   (req_i.option_code),
    .message_kind_i  (req_i.message_kind),
    .body_length_i   (req_i.body_length),
    .status_o        (rsp_o.status),
    .hit_dest_o      (rsp_o.hit_dest),
    .hit_source_o    (rsp_o.hit_source),
    .hit_serial_o    (rsp_o.hit_serial),
    .hit_option_o    (rsp_o.hit_option),
    .hit_kind_o      (rsp_o.hit_kind),
    .hit_length_o    (rsp_o.hit_length),
    .entries_left_o  (rsp_o.entries_left)
  );

`ifndef NO_ASSERTIONS
  // one item in flight: no beat accepted right after another
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while another is in flight");

  // a refused enqueue only happens at full occupancy
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == STAT_FULL |-> rsp_o.entries_left == DEPTH_CNT)
    else $error("full status with free slots");

  // occupancy never exceeds the depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.entries_left <= DEPTH_CNT)
    else $error("entry count above depth");

  // a failed operation returns no entry
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != STAT_OK |->
      rsp_o.hit_serial == '0 && rsp_o.hit_source == '0 && rsp_o.hit_length == '0)
    else $error("entry data on a failed operation");
`endif

endmodule

// File: src/kmf_datapath.sv
// kmf_datapath: slot memories, ring links, head/tail/count and result registers
// driven by kmf_ctrl_t commands; depends on kmf_pkg
module kmf_datapath import kmf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH),
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kmf_ctrl_t        ctrl_i,
  output kmf_stat_t        stat_o,
  input  cmd_e             cmd_i,
  input  logic [7:0]       dest_module_i,
  input  logic [7:0]       source_module_i,
  input  logic [31:0]      serial_number_i,
  input  logic [7:0]       option_code_i,
  input  logic [15:0]      message_kind_i,
  input  logic [15:0]      body_length_i,
  output logic [1:0]       status_o,
  output logic [7:0]       hit_dest_o,
  output logic [7:0]       hit_source_o,
  output logic [31:0]      hit_serial_o,
  output logic [7:0]       hit_option_o,
  output logic [15:0]      hit_kind_o,
  output logic [15:0]      hit_length_o,
  output logic [CNT_W-1:0] entries_left_o
);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  // captured request
  cmd_e        req_cmd_q;
  logic [7:0]  req_dst_q, req_src_q, req_opt_q;
  logic [31:0] req_ser_q;
  logic [15:0] req_knd_q, req_len_q;

  // slot memories: key {src, ser, opt}, info {dst, kind, len}, ring link
  logic [47:0]      key_mem  [QUEUE_DEPTH];
  logic [39:0]      info_mem [QUEUE_DEPTH];
  logic [IDX_W-1:0] link_mem [QUEUE_DEPTH];

  logic [47:0]      key_rd_q;
  logic [39:0]      info_rd_q;
  logic [IDX_W-1:0] link_rd_q, rd_slot_q, prev_q;

  // queue state
  logic [QUEUE_DEPTH-1:0] valid_q;
  logic [IDX_W-1:0]       head_q, tail_q, scan_q;
  logic [CNT_W-1:0]       count_q, walk_q;

  // unlink operands: removed slot, predecessor, successor of removed slot
  logic [IDX_W-1:0] m_q, p_q, lm_q;

  // result held until the output register frees up
  stat_e       res_status_q;
  logic [39:0] res_info_q;
  logic [47:0] res_key_q;

  logic [IDX_W-1:0] rd_addr, prev_d, link_wa, link_wd;
  logic             link_we;
  logic             key_hit;

  // request capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      req_cmd_q <= cmd_i;
      req_dst_q <= dest_module_i;
      req_src_q <= source_module_i;
      req_ser_q <= serial_number_i;
      req_opt_q <= option_code_i;
      req_knd_q <= message_kind_i;
      req_len_q <= body_length_i;
    end
  end

  // read address select; predecessor follows the walk
  always_comb begin
    unique case (ctrl_i.rd_sel)
      RD_TAIL: rd_addr = tail_q;
      RD_HEAD: rd_addr = head_q;
      RD_LINK: rd_addr = link_rd_q;
      default: rd_addr = tail_q;
    endcase
    prev_d = (ctrl_i.rd_sel == RD_LINK) ? rd_slot_q : tail_q;
  end

  // registered memory read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      key_rd_q  <= key_mem[rd_addr];
      info_rd_q <= info_mem[rd_addr];
      link_rd_q <= link_mem[rd_addr];
      rd_slot_q <= rd_addr;
      prev_q    <= prev_d;
    end
  end

  // link write port: new slot on enqueue, else links[p] <= lm
  always_comb begin
    link_we = ctrl_i.enq_write || ctrl_i.link_wr_pl;
    if (ctrl_i.enq_write) begin
      link_wa = scan_q;
      link_wd = (count_q == '0) ? scan_q : head_q;
    end else begin
      link_wa = p_q;
      link_wd = lm_q;
    end
  end

  // memory writes
  always_ff @(posedge clk_i) begin
    if (ctrl_i.enq_write) begin
      key_mem[scan_q]  <= {req_src_q, req_ser_q, req_opt_q};
      info_mem[scan_q] <= {req_dst_q, req_knd_q, req_len_q};
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
  end

  // unlink operand capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.enq_write) begin
      m_q  <= scan_q;
      p_q  <= tail_q;
      lm_q <= scan_q;
    end else begin
      case (ctrl_i.ul_sel)
        UL_FROM_RD: begin
          m_q  <= rd_slot_q;
          p_q  <= prev_q;
          lm_q <= link_rd_q;
        end
        UL_TAIL_PRED: begin
          m_q  <= tail_q;
          p_q  <= rd_slot_q;
          lm_q <= head_q;
        end
        default: ;
      endcase
    end
  end

  // queue control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      scan_q  <= '0;
      walk_q  <= '0;
    end else begin
      if (ctrl_i.scan_clr) begin
        scan_q <= '0;
      end else if (ctrl_i.scan_inc) begin
        scan_q <= scan_q + IDX_W'(1);
      end
      if (ctrl_i.walk_start) begin
        walk_q <= CNT_W'(1);
      end else if (ctrl_i.walk_inc) begin
        walk_q <= walk_q + CNT_W'(1);
      end
      if (ctrl_i.enq_write) begin
        valid_q[scan_q] <= 1'b1;
        tail_q          <= scan_q;
        count_q         <= count_q + CNT_W'(1);
        if (count_q == '0) begin
          head_q <= scan_q;
        end
      end else if (ctrl_i.unlink) begin
        valid_q[m_q] <= 1'b0;
        if (count_q <= CNT_W'(1)) begin
          count_q <= '0;
          tail_q  <= '0;
        end else begin
          count_q <= count_q - CNT_W'(1);
          if (tail_q == m_q) begin
            tail_q <= p_q;
          end
          if (head_q == m_q) begin
            head_q <= lm_q;
          end
        end
      end
    end
  end

  // key compare against the entry on the read bus
  always_comb begin
    case (req_cmd_q)
      CMD_FIND_SO, CMD_REM_SO:
        key_hit = (key_rd_q[47:40] == req_src_q) && (key_rd_q[7:0] == req_opt_q);
      CMD_FIND_SER, CMD_REM_SER:
        key_hit = (key_rd_q[39:8] == req_ser_q);
      default:
        key_hit = (key_rd_q[47:40] == req_src_q) && (key_rd_q[39:8] == req_ser_q);
    endcase
  end

  // status to controller
  always_comb begin
    stat_o.cmd          = req_cmd_q;
    stat_o.empty        = (count_q == '0);
    stat_o.single       = (count_q == CNT_W'(1));
    stat_o.full         = (count_q == DEPTH_CNT);
    stat_o.match        = key_hit;
    stat_o.rd_is_tail   = (rd_slot_q == tail_q);
    stat_o.link_is_tail = (link_rd_q == tail_q);
    stat_o.scan_free    = !valid_q[scan_q];
    stat_o.walk_last    = (walk_q == count_q);
  end

  // result and output registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_we) begin
      res_status_q <= ctrl_i.res_status;
      res_key_q    <= ctrl_i.res_hit ? key_rd_q : '0;
      res_info_q   <= ctrl_i.res_hit ? info_rd_q : '0;
    end
    if (ctrl_i.out_load) begin
      status_o       <= res_status_q;
      hit_dest_o     <= res_info_q[39:32];
      hit_kind_o     <= res_info_q[31:16];
      hit_length_o   <= res_info_q[15:0];
      hit_source_o   <= res_key_q[47:40];
      hit_serial_o   <= res_key_q[39:8];
      hit_option_o   <= res_key_q[7:0];
      entries_left_o <= count_q;
    end
  end

endmodule

// File: src/kmf_ctrl.sv
// kmf_ctrl: sequencing state machine of the keyed message fifo
// issues kmf_ctrl_t commands, reads kmf_stat_t; depends on kmf_pkg
module kmf_ctrl import kmf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cmd_e      in_cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  kmf_stat_t stat_i,
  output kmf_ctrl_t ctrl_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_ENQ_LINK, S_PEEK, S_DEQ, S_WALK, S_PRED, S_UPDATE, S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          if (in_cmd_i == CMD_ENQ) begin
            if (stat_i.full) begin
              ctrl_o.res_we     = 1'b1;
              ctrl_o.res_status = STAT_FULL;
              state_d           = S_RESULT;
            end else begin
              ctrl_o.scan_clr = 1'b1;
              state_d         = S_SCAN;
            end
          end else if (stat_i.empty) begin
            ctrl_o.res_we     = 1'b1;
            ctrl_o.res_status = STAT_MISS;
            state_d           = S_RESULT;
          end else begin
            ctrl_o.rd_en = 1'b1;
            case (in_cmd_i)
              CMD_PEEK: begin
                ctrl_o.rd_sel = RD_HEAD;
                state_d       = S_PEEK;
              end
              CMD_DEQ: begin
                ctrl_o.rd_sel = RD_HEAD;
                state_d       = S_DEQ;
              end
              default: begin
                ctrl_o.rd_sel     = RD_TAIL;
                ctrl_o.walk_start = 1'b1;
                state_d           = S_WALK;
              end
            endcase
          end
        end
      end
      // look for the lowest free slot
      S_SCAN: begin
        if (stat_i.scan_free) begin
          ctrl_o.enq_write = 1'b1;
          if (stat_i.empty) begin
            ctrl_o.res_we     = 1'b1;
            ctrl_o.res_status = STAT_OK;
            state_d           = S_RESULT;
          end else begin
            state_d = S_ENQ_LINK;
          end
        end else begin
          ctrl_o.scan_inc = 1'b1;
        end
      end
      // old tail now points at the new slot
      S_ENQ_LINK: begin
        ctrl_o.link_wr_pl = 1'b1;
        ctrl_o.res_we     = 1'b1;
        ctrl_o.res_status = STAT_OK;
        state_d           = S_RESULT;
      end
      S_PEEK: begin
        ctrl_o.res_we     = 1'b1;
        ctrl_o.res_status = STAT_OK;
        ctrl_o.res_hit    = 1'b1;
        state_d           = S_RESULT;
      end
      S_DEQ: begin
        ctrl_o.ul_sel = UL_FROM_RD;
        state_d       = S_UPDATE;
      end
      // ring walk from the tail, one entry per cycle
      S_WALK: begin
        if (stat_i.match) begin
          if (stat_i.cmd == CMD_FIND_SO || stat_i.cmd == CMD_FIND_SER) begin
            ctrl_o.res_we     = 1'b1;
            ctrl_o.res_status = STAT_OK;
            ctrl_o.res_hit    = 1'b1;
            state_d           = S_RESULT;
          end else if (stat_i.rd_is_tail && !stat_i.single) begin
            ctrl_o.rd_en  = 1'b1;
            ctrl_o.rd_sel = RD_LINK;
            state_d       = S_PRED;
          end else begin
            ctrl_o.ul_sel = UL_FROM_RD;
            state_d       = S_UPDATE;
          end
        end else if (stat_i.walk_last) begin
          ctrl_o.res_we     = 1'b1;
          ctrl_o.res_status = STAT_MISS;
          state_d           = S_RESULT;
        end else begin
          ctrl_o.rd_en    = 1'b1;
          ctrl_o.rd_sel   = RD_LINK;
          ctrl_o.walk_inc = 1'b1;
        end
      end
      // find the entry whose link is the tail
      S_PRED: begin
        if (stat_i.link_is_tail) begin
          ctrl_o.ul_sel = UL_TAIL_PRED;
          state_d       = S_UPDATE;
        end else begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = RD_LINK;
        end
      end
      S_UPDATE: begin
        ctrl_o.unlink     = 1'b1;
        ctrl_o.link_wr_pl = 1'b1;
        ctrl_o.res_we     = 1'b1;
        ctrl_o.res_status = STAT_OK;
        state_d           = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output beat valid
  always_comb begin
    if (ctrl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: tb/sv/kmf_checker.sv
// kmf_checker: watches the request and result channels of the keyed message fifo,
// predicts each result beat and compares it field by field
// depends on kmf_pkg and kmf_if
`timescale 1ns / 100ps

module kmf_checker import kmf_pkg::*; #(
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kmf_req_if          req,
  kmf_rsp_if          rsp,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  dest;
    logic [7:0]  src;
    logic [31:0] serial;
    logic [7:0]  opt;
    logic [15:0] kind;
    logic [15:0] len;
    logic [4:0]  left;
  } outcome_t;

  // shadow of the slot ring
  logic [7:0]  sh_src [DEPTH];
  logic [31:0] sh_ser [DEPTH];
  logic [7:0]  sh_opt [DEPTH];
  logic [7:0]  sh_dst [DEPTH];
  logic [15:0] sh_knd [DEPTH];
  logic [15:0] sh_len [DEPTH];
  int unsigned sh_next [DEPTH];
  bit          sh_used [DEPTH];
  int unsigned sh_tail;
  int unsigned sh_count;

  outcome_t expected_results[$];

  function automatic bit key_hit(cmd_e c, int unsigned s, logic [7:0] src,
                                 logic [31:0] ser, logic [7:0] opt);
    case (c)
      CMD_FIND_SO, CMD_REM_SO:   return sh_src[s] == src && sh_opt[s] == opt;
      CMD_FIND_SER, CMD_REM_SER: return sh_ser[s] == ser;
      default:                   return sh_src[s] == src && sh_ser[s] == ser;
    endcase
  endfunction

  function automatic void fill_hit(ref outcome_t o, input int unsigned s);
    o.dest = sh_dst[s]; o.src = sh_src[s]; o.serial = sh_ser[s];
    o.opt = sh_opt[s]; o.kind = sh_knd[s]; o.len = sh_len[s];
  endfunction

  function automatic void drop_slot(int unsigned m, int unsigned p);
    if (sh_count <= 1) begin
      sh_count = 0;
      sh_tail = 0;
    end else begin
      sh_next[p] = sh_next[m];
      if (sh_tail == m) sh_tail = p;
      sh_count--;
    end
    sh_used[m] = 0;
  endfunction

  // apply one command beat to the shadow queue
  function automatic outcome_t apply_command(cmd_e c, logic [7:0] dst, logic [7:0] src,
                                             logic [31:0] ser, logic [7:0] opt,
                                             logic [15:0] knd, logic [15:0] len);
    outcome_t o;
    int unsigned node, prev, free, k;
    bit found;
    o = '0;
    o.status = STAT_OK;
    if (c == CMD_ENQ) begin
      free = DEPTH;
      for (k = 0; k < DEPTH; k++)
        if (!sh_used[k] && free == DEPTH) free = k;
      if (sh_count >= DEPTH || free == DEPTH) o.status = STAT_FULL;
      else begin
        sh_src[free] = src; sh_ser[free] = ser; sh_opt[free] = opt;
        sh_dst[free] = dst; sh_knd[free] = knd; sh_len[free] = len;
        sh_used[free] = 1;
        if (sh_count == 0) sh_next[free] = free;
        else begin
          sh_next[free] = sh_next[sh_tail];
          sh_next[sh_tail] = free;
        end
        sh_tail = free;
        sh_count++;
      end
    end else if (sh_count == 0) begin
      o.status = STAT_MISS;
    end else if (c == CMD_PEEK) begin
      fill_hit(o, sh_next[sh_tail]);
    end else if (c == CMD_DEQ) begin
      drop_slot(sh_next[sh_tail], sh_tail);
    end else begin
      // tail first, then head toward tail
      node = sh_tail; prev = sh_tail; found = 0;
      for (k = 0; k < sh_count && !found; k++) begin
        if (key_hit(c, node, src, ser, opt)) found = 1;
        else begin
          prev = node;
          node = sh_next[node];
        end
      end
      if (!found) o.status = STAT_MISS;
      else if (c == CMD_FIND_SO || c == CMD_FIND_SER) fill_hit(o, node);
      else begin
        if (node == sh_tail) begin
          prev = sh_tail;
          while (sh_next[prev] != sh_tail) prev = sh_next[prev];
        end
        drop_slot(node, prev);
      end
    end
    o.left = sh_count[4:0];
    return o;
  endfunction

  // predict on request beats, compare on result beats
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        sh_used[i] = 0;
        sh_next[i] = 0;
      end
      sh_tail = 0;
      sh_count = 0;
      errors_o <= 0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (req.valid && req.ready)
        expected_results.push_back(apply_command(cmd_e'(req.cmd), req.dest_module,
          req.source_module, req.serial_number, req.option_code, req.message_kind,
          req.body_length));
      if (rsp.valid && rsp.ready) begin
        got = {rsp.status, rsp.hit_dest, rsp.hit_source, rsp.hit_serial, rsp.hit_option,
               rsp.hit_kind, rsp.hit_length, 5'(rsp.entries_left)};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat, actual %h", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch expected st=%0d d=%h s=%h ser=%h o=%h k=%h l=%h n=%0d",
                     $time, want.status, want.dest, want.src, want.serial, want.opt,
                     want.kind, want.len, want.left);
            $display("%0t:                 actual   st=%0d d=%h s=%h ser=%h o=%h k=%h l=%h n=%0d",
                     $time, got.status, got.dest, got.src, got.serial, got.opt,
                     got.kind, got.len, got.left);
            errors_o <= errors_o + 1;
          end
        end
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

// File: tb/sv/tb.sv
// tb: stimulus and verdict for the keyed message fifo
// depends on kmf_pkg, kmf_if, keyed_message_fifo and kmf_checker
`timescale 1ns / 100ps

module tb import kmf_pkg::*;;

  localparam int unsigned DEPTH     = DEF_QUEUE_DEPTH;
  localparam int unsigned N_RANDOM  = 1600;
  localparam int unsigned MAX_CYCLE = 400000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned errors;
  int unsigned pending;
  int unsigned cycle_count;
  bit          calm;      // no idling on either side
  bit          rsp_stall_on;

  kmf_req_if req ();
  kmf_rsp_if rsp ();

  keyed_message_fifo DUT (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp));
  kmf_checker chk (.clk_i(clk_i), .rst_ni(rst_ni), .req(req), .rsp(rsp),
                   .errors_o(errors), .pending_o(pending));

  // keys kept small so searches hit often
  logic [7:0]  used_src [$];
  logic [31:0] used_ser [$];
  logic [7:0]  used_opt [$];

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // timeout watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rsp.ready <= 1'b0;
    else rsp.ready <= calm || !rsp_stall_on || $urandom_range(99) >= 11;
  end

  // one request beat, with an optional idle gap first
  task automatic send(cmd_e c, logic [7:0] dst, logic [7:0] src, logic [31:0] ser,
                      logic [7:0] opt, logic [15:0] knd, logic [15:0] len);
    while (!calm && $urandom_range(99) < 11) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.cmd <= c;
    req.dest_module <= dst;
    req.source_module <= src;
    req.serial_number <= ser;
    req.option_code <= opt;
    req.message_kind <= knd;
    req.body_length <= len;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  task automatic idle_req();
    req.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    idle_req();
    while (pending != 0) @(posedge clk_i);
  endtask

  // random beat: keys mostly drawn from values already queued
  task automatic send_random(int unsigned enq_weight);
    cmd_e        c;
    logic [7:0]  src, opt;
    logic [31:0] ser;
    int unsigned n;
    c = ($urandom_range(99) < enq_weight) ? CMD_ENQ : cmd_e'($urandom_range(7));
    n = used_src.size();
    if (n != 0 && $urandom_range(9) < 8) begin
      src = used_src[$urandom_range(n - 1)];
      ser = used_ser[$urandom_range(n - 1)];
      opt = used_opt[$urandom_range(n - 1)];
      if ($urandom_range(1)) begin
        n = $urandom_range(n - 1);
        src = used_src[n]; ser = used_ser[n]; opt = used_opt[n];
      end
    end else begin
      src = 8'($urandom_range(3));
      ser = $urandom_range(1) ? $urandom() : $urandom_range(3);
      opt = 8'($urandom_range(3));
      if ($urandom_range(7) == 0) begin
        src = 8'($urandom()); opt = 8'($urandom());
      end
    end
    if (c == CMD_ENQ) begin
      used_src.push_back(src); used_ser.push_back(ser); used_opt.push_back(opt);
      if (used_src.size() > 24) begin
        void'(used_src.pop_front()); void'(used_ser.pop_front());
        void'(used_opt.pop_front());
      end
    end
    send(c, 8'($urandom()), src, ser, opt, 16'($urandom()), 16'($urandom()));
  endtask

  initial begin
    calm = 1;
    rsp_stall_on = 1;
    cycle_count = 0;
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.cmd = CMD_ENQ;
    req.dest_module = '0;
    req.source_module = '0;
    req.serial_number = '0;
    req.option_code = '0;
    req.message_kind = '0;
    req.body_length = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue on every non-enqueue command
    for (int c = 1; c < 8; c++) send(cmd_e'(c), 0, 0, 0, 0, 0, 0);
    // extremes of every field
    send(CMD_ENQ, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    send(CMD_ENQ, 8'h00, 8'h00, 32'h0000_0000, 8'h00, 16'h0000, 16'h0000);
    send(CMD_ENQ, 8'h5A, 8'h11, 32'h1234_5678, 8'h22, 16'hA5A5, 16'h5A5A);
    send(CMD_PEEK, 0, 0, 0, 0, 0, 0);
    send(CMD_FIND_SO, 0, 8'h11, 0, 8'h22, 0, 0);          // tail hit
    send(CMD_FIND_SER, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);      // head hit
    send(CMD_FIND_SO, 0, 8'h11, 0, 8'h23, 0, 0);          // no match
    send(CMD_REM_SS, 0, 8'h11, 32'h1234_5678, 0, 0, 0);   // remove the tail
    send(CMD_REM_SER, 0, 0, 32'h0, 0, 0, 0);               // remove new tail
    send(CMD_REM_SO, 0, 8'hFF, 0, 8'hFF, 0, 0);           // remove the only entry
    send(CMD_DEQ, 0, 0, 0, 0, 0, 0);
    // fill past full, then empty with dequeues
    for (int i = 0; i <= DEPTH; i++)
      send(CMD_ENQ, 8'(i), 8'(i), 32'(i), 8'(i), 16'(i), 16'(i));
    send(CMD_REM_SER, 0, 0, 32'd5, 0, 0, 0);               // middle removal
    send(CMD_ENQ, 1, 2, 3, 4, 5, 6);                      // reuse freed slot
    for (int i = 0; i <= DEPTH; i++) send(CMD_DEQ, 0, 0, 0, 0, 0, 0);
    drain();

    // random part: first a calm stretch, then idling on both sides
    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i < 250);
      send_random((i % 400) < 200 ? 55 : 30);
      if (i == 800) drain();   // sender holds until every result is back
    end
    drain();
    repeat (2 * DEPTH + 20) @(posedge clk_i);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
